>>> rtl/fvn_pkg.sv
// Shared types, constants and constant functions of the fractal value noise block.
// Used by every module in rtl/; depends on nothing else.
package fvn_pkg;

  localparam int unsigned MAX_OCTAVES_DEF   = 8;
  localparam int unsigned FRACTION_BITS_DEF = 8;

  localparam int unsigned COORD_W = 18;
  localparam int unsigned PERS_W  = 16;
  localparam int unsigned COUNT_W = 4;
  localparam int unsigned AMP_W   = 17;
  localparam int unsigned ACC_W   = 24;
  localparam int unsigned NOISE_W = 21;
  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_PERSISTENCE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_COUNT = 8'd1;

  localparam logic [PERS_W-1:0]  PERSISTENCE_RST  = 16'd32768;
  localparam logic [COUNT_W-1:0] OCTAVE_COUNT_RST = 4'd4;
  localparam logic [AMP_W-1:0]   AMP_ONE          = 17'd65536;

  localparam logic [31:0] HASH_ROW_MUL = 32'd57;
  localparam logic [31:0] HASH_MUL     = 32'd15731;
  localparam logic [31:0] HASH_ADD_A   = 32'd789221;
  localparam logic [31:0] HASH_ADD_B   = 32'd1376312589;
  localparam logic [31:0] HASH_MASK    = 32'h7fffffff;
  localparam logic signed [31:0] LAT_ONE = 32'sd1073741824;

  localparam logic signed [ACC_W-1:0] OUT_MAX = 24'sd524288;
  localparam logic signed [ACC_W-1:0] OUT_MIN = -24'sd524288;

  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned ONE_Q30 = 64'd1073741824;

  // Payload that moves from one octave cell to the next.
  typedef struct packed {
    logic [COORD_W-1:0]       x;
    logic [COORD_W-1:0]       y;
    logic [COUNT_W-1:0]       count;
    logic [AMP_W-1:0]         amp;
    logic signed [ACC_W-1:0]  acc;
  } link_t;

  // Cosine blend weight for fraction code k, evaluated at elaboration.
  function automatic logic [AMP_W-1:0] cos_weight(int unsigned k, int unsigned fb);
    longint unsigned u;
    longint unsigned u2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned w;
    u  = (PI_Q30 * longint'(k)) >> (fb + 1);
    u2 = (u * u) >> 30;
    t  = ONE_Q30;
    t  = ONE_Q30 - ((u2 * t) >> 30) / 110;
    t  = ONE_Q30 - ((u2 * t) >> 30) / 72;
    t  = ONE_Q30 - ((u2 * t) >> 30) / 42;
    t  = ONE_Q30 - ((u2 * t) >> 30) / 20;
    t  = ONE_Q30 - ((u2 * t) >> 30) / 6;
    s  = (u * t) >> 30;
    w  = (s * s + (64'd1 << 43)) >> 44;
    if (w > 64'd65536) begin
      w = 64'd65536;
    end
    return AMP_W'(w);
  endfunction

  // a + floor((b - a) * w / 2^16)
  function automatic logic signed [17:0] blend(logic signed [17:0] a,
                                               logic signed [17:0] b,
                                               logic [AMP_W-1:0] w);
    logic signed [18:0] d;
    logic signed [36:0] p;
    d = 19'(b) - 19'(a);
    p = 37'(d) * 37'(signed'({1'b0, w}));
    return 18'(37'(a) + (p >>> 16));
  endfunction

endpackage

>>> rtl/fractal_value_noise_2d.sv
// Top level of the fractal value noise block: config registers, octave chain, output stage.
// Depends on fvn_pkg, fvn_cell and fvn_hash.
//
// Usage: a point (x_coord_i, y_coord_i) in unsigned Q10.8 is one input
// transaction on in_valid_i / in_stall_o. Each point yields exactly one
// output transaction on out_valid_o / out_stall_i carrying noise_value_o, a
// signed Q4.16 sum of octave noise saturated to [-8.0, +8.0].
// The block is a chain of MAX_OCTAVES identical octave cells. Each cell is a
// ten-stage pipeline (four hash stages, two smoothing stages, two blend
// stages, scale and accumulate) and hands the running sum to its neighbor.
// Octaves at or above octave_count still pass through but add nothing.
// A new point is accepted every cycle unless the receiver stalls with a
// result waiting; the input register, the cell chain and the result
// register lie between a point and its result.
// When the receiver stalls with a result waiting, the whole chain holds and
// in_stall_o rises in the same cycle; nothing is lost or repeated.
// Configuration transactions (index 0 persistence, index 1 octave_count) are
// always ready and are meant to be issued while no point is in flight.
// Reset clears all valid flags and loads persistence 0.5 and four octaves.
module fractal_value_noise_2d #(
  parameter int unsigned MAX_OCTAVES   = fvn_pkg::MAX_OCTAVES_DEF,
  parameter int unsigned FRACTION_BITS = fvn_pkg::FRACTION_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [fvn_pkg::COORD_W-1:0]        x_coord_i,
  input  logic [fvn_pkg::COORD_W-1:0]        y_coord_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [fvn_pkg::NOISE_W-1:0] noise_value_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [fvn_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [fvn_pkg::PERS_W-1:0]         cfg_data_i
);

  logic [fvn_pkg::PERS_W-1:0]  persistence_q;
  logic [fvn_pkg::COUNT_W-1:0] octave_count_q;
  logic en;

  logic           chain_vld [MAX_OCTAVES+1];
  fvn_pkg::link_t chain_lnk [MAX_OCTAVES+1];

  logic in_vld_q;
  fvn_pkg::link_t in_lnk_q;
  logic out_vld_q;
  logic signed [fvn_pkg::NOISE_W-1:0] noise_q;
  logic signed [fvn_pkg::ACC_W-1:0] total, sat;

  // The chain advances unless a finished result is held by the receiver.
  assign en          = !(out_vld_q && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      persistence_q  <= fvn_pkg::PERSISTENCE_RST;
      octave_count_q <= fvn_pkg::OCTAVE_COUNT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        fvn_pkg::REG_PERSISTENCE:  persistence_q  <= cfg_data_i;
        fvn_pkg::REG_OCTAVE_COUNT: octave_count_q <= cfg_data_i[fvn_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register: the first cell sees a full amplitude and an empty sum.
  always_ff @(posedge clk_i) begin
    if (en) begin
      in_lnk_q.x     <= x_coord_i;
      in_lnk_q.y     <= y_coord_i;
      in_lnk_q.count <= octave_count_q;
      in_lnk_q.amp   <= fvn_pkg::AMP_ONE;
      in_lnk_q.acc   <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      in_vld_q  <= in_valid_i;
      out_vld_q <= chain_vld[MAX_OCTAVES];
    end
  end

  assign chain_vld[0] = in_vld_q;
  assign chain_lnk[0] = in_lnk_q;

  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_oct
    fvn_cell #(
      .OCT           (i),
      .FRACTION_BITS (FRACTION_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .en_i          (en),
      .persistence_i (persistence_q),
      .valid_i       (chain_vld[i]),
      .link_i        (chain_lnk[i]),
      .valid_o       (chain_vld[i+1]),
      .link_o        (chain_lnk[i+1])
    );
  end

  // Saturate the octave sum to the Q4.16 output range.
  always_comb begin
    total = chain_lnk[MAX_OCTAVES].acc;
    if (total > fvn_pkg::OUT_MAX) begin
      sat = fvn_pkg::OUT_MAX;
    end else if (total < fvn_pkg::OUT_MIN) begin
      sat = fvn_pkg::OUT_MIN;
    end else begin
      sat = total;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      noise_q <= fvn_pkg::NOISE_W'(sat);
    end
  end

  assign out_valid_o   = out_vld_q;
  assign noise_value_o = noise_q;

endmodule

>>> rtl/fvn_hash.sv
// Four-stage pipelined integer hash of one lattice point, giving its Q30 value.
// Depends on fvn_pkg.
module fvn_hash (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [31:0]        xc_i,
  input  logic [31:0]        yc_i,
  output logic signed [31:0] lat_o
);

  logic [31:0] n0;
  logic [31:0] n_q, n_b_q, n_c_q;
  logic [31:0] p_q, q_q;
  logic [31:0] m;
  logic signed [31:0] lat_q;

  always_comb begin
    n0 = xc_i + yc_i * fvn_pkg::HASH_ROW_MUL;
    m  = (n_c_q * q_q + fvn_pkg::HASH_ADD_B) & fvn_pkg::HASH_MASK;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q   <= (n0 << 13) ^ n0;
      p_q   <= n_q * n_q;
      n_b_q <= n_q;
      q_q   <= p_q * fvn_pkg::HASH_MUL + fvn_pkg::HASH_ADD_A;
      n_c_q <= n_b_q;
      lat_q <= fvn_pkg::LAT_ONE - signed'(m);
    end
  end

  assign lat_o = lat_q;

endmodule

>>> rtl/fvn_cell.sv
// One octave cell: hashes a 4x4 lattice patch, smooths, blends and accumulates.
// Depends on fvn_pkg and fvn_hash.
module fvn_cell #(
  parameter int unsigned OCT           = 0,
  parameter int unsigned FRACTION_BITS = fvn_pkg::FRACTION_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic [fvn_pkg::PERS_W-1:0] persistence_i,
  input  logic                       valid_i,
  input  fvn_pkg::link_t             link_i,
  output logic                       valid_o,
  output fvn_pkg::link_t             link_o
);

  localparam int unsigned SB_N = 9;
  localparam int unsigned W_N  = 2 ** FRACTION_BITS;
  localparam int unsigned SX_W = 50;

  logic [fvn_pkg::AMP_W-1:0] wtab [W_N];
  logic [SX_W-1:0] sx_in, sx_b1, sx_b2;
  logic [31:0] xi, yi;
  logic signed [31:0] lat [4][4];

  fvn_pkg::link_t sb_q [SB_N];
  logic [SB_N-1:0] vld_q;

  logic signed [33:0] cs_q [4];
  logic signed [33:0] ss_q [4];
  logic signed [31:0] c_q  [4];
  logic signed [17:0] sm_q [4];
  logic signed [17:0] top_q, bot_q, nz_q;
  logic signed [34:0] prod_q;
  logic [fvn_pkg::AMP_W-1:0] ampn_q;
  logic [fvn_pkg::AMP_W-1:0] wx, wy;
  logic signed [fvn_pkg::ACC_W-1:0] contrib;
  logic oct_on;
  fvn_pkg::link_t link_q;
  logic valid_q;

  for (genvar k = 0; k < W_N; k++) begin : g_wtab
    localparam logic [fvn_pkg::AMP_W-1:0] WK = fvn_pkg::cos_weight(k, FRACTION_BITS);
    assign wtab[k] = WK;
  end

  always_comb begin
    sx_in  = SX_W'(link_i.x) << OCT;
    xi     = sx_in[FRACTION_BITS +: 32];
    sx_b1  = SX_W'(link_i.y) << OCT;
    yi     = sx_b1[FRACTION_BITS +: 32];
    sx_b2  = SX_W'(sb_q[5].x) << OCT;
    wx     = wtab[sx_b2[FRACTION_BITS-1:0]];
  end

  logic [SX_W-1:0] sy_b;
  always_comb begin
    sy_b = SX_W'(sb_q[6].y) << OCT;
    wy   = wtab[sy_b[FRACTION_BITS-1:0]];
  end

  // Lattice patch covers columns xi-1 .. xi+2 and rows yi-1 .. yi+2.
  for (genvar b = 0; b < 4; b++) begin : g_row
    for (genvar a = 0; a < 4; a++) begin : g_col
      fvn_hash u_hash (
        .clk_i (clk_i),
        .en_i  (en_i),
        .xc_i  (xi + 32'(a) - 32'd1),
        .yc_i  (yi + 32'(b) - 32'd1),
        .lat_o (lat[b][a])
      );
    end
  end

  for (genvar j = 0; j < 4; j++) begin : g_smooth
    localparam int CA = 1 + (j % 2);
    localparam int CB = 1 + (j / 2);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cs_q[j] <= 34'(lat[CB-1][CA-1]) + 34'(lat[CB-1][CA+1])
                 + 34'(lat[CB+1][CA-1]) + 34'(lat[CB+1][CA+1]);
        ss_q[j] <= 34'(lat[CB][CA-1]) + 34'(lat[CB][CA+1])
                 + 34'(lat[CB-1][CA]) + 34'(lat[CB+1][CA]);
        c_q[j]  <= lat[CB][CA];
        sm_q[j] <= 18'((36'(cs_q[j]) + (36'(ss_q[j]) <<< 1) + (36'(c_q[j]) <<< 2)) >>> 18);
      end
    end
  end

  always_comb begin
    oct_on  = 5'(OCT) < {1'b0, sb_q[8].count};
    contrib = oct_on ? fvn_pkg::ACC_W'(prod_q >>> 16) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sb_q[0] <= link_i;
      for (int k = 1; k < SB_N; k++) begin
        sb_q[k] <= sb_q[k-1];
      end
      top_q  <= fvn_pkg::blend(sm_q[0], sm_q[1], wx);
      bot_q  <= fvn_pkg::blend(sm_q[2], sm_q[3], wx);
      nz_q   <= fvn_pkg::blend(top_q, bot_q, wy);
      prod_q <= 35'(nz_q) * 35'(signed'({1'b0, sb_q[7].amp}));
      ampn_q <= fvn_pkg::AMP_W'((33'(sb_q[7].amp) * 33'(persistence_i)) >> 16);
      link_q.x     <= sb_q[8].x;
      link_q.y     <= sb_q[8].y;
      link_q.count <= sb_q[8].count;
      link_q.amp   <= ampn_q;
      link_q.acc   <= sb_q[8].acc + contrib;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      valid_q <= 1'b0;
    end else if (en_i) begin
      vld_q   <= {vld_q[SB_N-2:0], valid_i};
      valid_q <= vld_q[SB_N-1];
    end
  end

  assign valid_o = valid_q;
  assign link_o  = link_q;

endmodule

>>> rtl/fvn_checker.sv
// Port-level checker for the fractal value noise block, bound to the top level.
// Depends on fvn_pkg and fractal_value_noise_2d.
module fvn_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_stall_o,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic signed [fvn_pkg::NOISE_W-1:0] noise_value_o,
  input logic                               cfg_valid_i,
  input logic                               cfg_ready_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(noise_value_o))
    else $error("stalled result changed or dropped");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (noise_value_o <= 21'sd524288) && (noise_value_o >= -21'sd524288))
    else $error("noise value outside saturation range");

  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output stage is empty");

  a_stall_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |-> !in_stall_o)
    else $error("input stalled while result is being taken");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind fractal_value_noise_2d fvn_checker u_fvn_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .noise_value_o (noise_value_o),
  .cfg_valid_i   (cfg_valid_i),
  .cfg_ready_o   (cfg_ready_o)
);

>>> tb/tb_top.sv
// Self-checking testbench for fractal_value_noise_2d: drives points, predicts each noise value.
// Depends on fvn_pkg and the RTL in rtl/; needs nothing else.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned LATENCY = 10 * fvn_pkg::MAX_OCTAVES_DEF + 2;
  localparam int unsigned FB = fvn_pkg::FRACTION_BITS_DEF;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [fvn_pkg::COORD_W-1:0] x_coord_i = '0;
  logic [fvn_pkg::COORD_W-1:0] y_coord_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [fvn_pkg::NOISE_W-1:0] noise_value_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [fvn_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [fvn_pkg::PERS_W-1:0] cfg_data_i = '0;

  fractal_value_noise_2d u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor copy of the two configuration registers.
  logic [fvn_pkg::PERS_W-1:0] model_pers;
  logic [fvn_pkg::COUNT_W-1:0] model_octaves;

  // Expected noise values, oldest first.
  logic signed [fvn_pkg::NOISE_W-1:0] noise_queue[$];
  int unsigned error_count = 0;
  longint cycle_count = 0;

  // Percent chances of idling for the sender and of stalling for the receiver.
  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;

  // Cosine weights, built once by the testbench's own series evaluation.
  longint cos_lut[0:(1<<FB)-1];

  function automatic longint fl_shift(longint v, int unsigned s);
    return v >>> s;  // arithmetic shift on a signed 64-bit value is floor
  endfunction

  function automatic longint weight_of(int unsigned k);
    longint unsigned u, u2, t, s, w;
    u  = (64'd3373259426 * k) >> (FB + 1);
    u2 = (u * u) >> 30;
    t  = 64'd1 << 30;
    t  = (64'd1 << 30) - ((u2 * t) >> 30) / 110;
    t  = (64'd1 << 30) - ((u2 * t) >> 30) / 72;
    t  = (64'd1 << 30) - ((u2 * t) >> 30) / 42;
    t  = (64'd1 << 30) - ((u2 * t) >> 30) / 20;
    t  = (64'd1 << 30) - ((u2 * t) >> 30) / 6;
    s  = (u * t) >> 30;
    w  = (s * s + (64'd1 << 43)) >> 44;
    if (w > 65536) w = 65536;
    return longint'(w);
  endfunction

  function automatic longint lattice(logic [31:0] xi, logic [31:0] yi);
    logic [31:0] n, m;
    n = xi + yi * 32'd57;
    n = (n << 13) ^ n;
    m = (n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fffffff;
    return longint'(1 << 30) - longint'(m);
  endfunction

  function automatic longint smoothed(logic [31:0] xi, logic [31:0] yi);
    longint c, sd, ce;
    c  = lattice(xi - 1, yi - 1) + lattice(xi - 1, yi + 1)
       + lattice(xi + 1, yi - 1) + lattice(xi + 1, yi + 1);
    sd = lattice(xi - 1, yi) + lattice(xi + 1, yi)
       + lattice(xi, yi - 1) + lattice(xi, yi + 1);
    ce = lattice(xi, yi);
    return fl_shift(c + 2 * sd + 4 * ce, 18);
  endfunction

  function automatic longint mix(longint a, longint b, longint w);
    return a + fl_shift((b - a) * w, 16);
  endfunction

  function automatic longint octave_value(longint unsigned sx, longint unsigned sy);
    logic [31:0] xi, yi;
    longint wx, wy, top, bot;
    xi  = 32'(sx >> FB);
    yi  = 32'(sy >> FB);
    wx  = cos_lut[sx & ((1 << FB) - 1)];
    wy  = cos_lut[sy & ((1 << FB) - 1)];
    top = mix(smoothed(xi, yi), smoothed(xi + 1, yi), wx);
    bot = mix(smoothed(xi, yi + 1), smoothed(xi + 1, yi + 1), wx);
    return mix(top, bot, wy);
  endfunction

  function automatic logic signed [fvn_pkg::NOISE_W-1:0] fractal_sum(
      logic [fvn_pkg::COORD_W-1:0] x, logic [fvn_pkg::COORD_W-1:0] y);
    int unsigned count;
    longint amp, total;
    count = 32'(model_octaves);
    amp   = 65536;
    total = 0;
    if (count > fvn_pkg::MAX_OCTAVES_DEF) count = fvn_pkg::MAX_OCTAVES_DEF;
    for (int unsigned i = 0; i < count; i++) begin
      total += fl_shift(octave_value(longint'(x) << i, longint'(y) << i) * amp, 16);
      amp = (amp * model_pers) >>> 16;
    end
    if (total > 524288) total = 524288;
    if (total < -524288) total = -524288;
    return fvn_pkg::NOISE_W'(total);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch: %s got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  // Receiver side: random stall and result checking at each rising edge.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (noise_queue.size() == 0) begin
        report_mismatch("unexpected noise_value", noise_value_o, 0);
      end else begin
        if (noise_value_o !== noise_queue[0])
          report_mismatch("noise_value", noise_value_o, noise_queue[0]);
        void'(noise_queue.pop_front());
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** fractal_value_noise_2d: FAILED **");
      $finish;
    end
  end

  // Sends one point; the valid stays high across back-to-back transactions.
  task automatic send_point(logic [fvn_pkg::COORD_W-1:0] x, logic [fvn_pkg::COORD_W-1:0] y);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    x_coord_i  <= x;
    y_coord_i  <= y;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    noise_queue.push_back(fractal_sum(x, y));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (noise_queue.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  // Configuration is written only when the chain is empty.
  task automatic write_reg(logic [fvn_pkg::CFG_IDX_W-1:0] idx,
                           logic [fvn_pkg::PERS_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    if (idx == fvn_pkg::REG_PERSISTENCE) model_pers = data;
    else if (idx == fvn_pkg::REG_OCTAVE_COUNT) model_octaves = data[fvn_pkg::COUNT_W-1:0];
  endtask

  task automatic test_directed();
    logic [fvn_pkg::COORD_W-1:0] top;
    top = '1;
    send_point('0, '0);
    send_point(top, top);
    send_point(top, '0);
    send_point('0, top);
    send_point(18'h00080, 18'h00080);
    send_point(18'h000ff, 18'h00100);
    send_point(18'h2aaaa, 18'h15555);
    drain();
    // Zero octaves gives zero noise.
    write_reg(fvn_pkg::REG_OCTAVE_COUNT, '0);
    send_point(18'h12345, 18'h3abcd);
    send_point(top, top);
    drain();
    // A count above the chain length is clamped.
    write_reg(fvn_pkg::REG_OCTAVE_COUNT, 16'd15);
    write_reg(fvn_pkg::REG_PERSISTENCE, 16'hffff);
    send_point(top, top);
    send_point(18'h01234, 18'h00777);
    send_point('0, '0);
    drain();
    write_reg(fvn_pkg::REG_OCTAVE_COUNT, 16'd8);
    write_reg(fvn_pkg::REG_PERSISTENCE, '0);
    send_point(top, 18'h00001);
    send_point(18'h00001, top);
    drain();
    // Unknown index is ignored by the block.
    write_reg(8'd7, 16'h1234);
    write_reg(8'hff, 16'h0001);
    send_point(18'h3c3c3, 18'h0f0f0);
    drain();
  endtask

  task automatic test_random(int unsigned count, int unsigned gap, int unsigned stall);
    logic [fvn_pkg::COORD_W-1:0] x, y;
    send_gap_pct   = gap;
    recv_stall_pct = stall;
    for (int unsigned i = 0; i < count; i++) begin
      if ((i % 80) == 0) begin
        drain();
        write_reg(fvn_pkg::REG_PERSISTENCE,
                  ($urandom_range(3) == 0) ? 16'hffff : 16'($urandom));
        write_reg(fvn_pkg::REG_OCTAVE_COUNT, 16'($urandom_range(15)));
      end
      x = 18'($urandom);
      y = 18'($urandom);
      if ($urandom_range(9) == 0) x = {fvn_pkg::COORD_W{x[0]}};
      send_point(x, y);
    end
    drain();
  endtask

  initial begin
    for (int k = 0; k < (1 << FB); k++) cos_lut[k] = weight_of(k);
    model_pers    = fvn_pkg::PERSISTENCE_RST;
    model_octaves = fvn_pkg::OCTAVE_COUNT_RST;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_gap_pct   = 10;
    recv_stall_pct = 20;
    test_directed();
    test_random(640, 8, 60);
    test_random(640, 60, 8);
    test_random(640, 0, 0);
    if (error_count == 0) begin
      $display("** fractal_value_noise_2d: PASSED **");
    end else begin
      $display("** fractal_value_noise_2d: FAILED **");
    end
    $finish;
  end

endmodule
